FILE: rtl/wsfu_pkg.sv
// shared types and constants of the websocket frame unmasker
`default_nettype none

package wsfu_pkg;

	// defaults for the top level parameters
	localparam int LENGTH_BITS_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 4;

	// width of the extended length field on the wire
	localparam int EXT_BITS = 64;

	// seven-bit length codes that announce an extended length
	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	// extended length byte counts
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

	localparam logic [31:0] LIMIT_RESET = 32'd65535;

	// what a queue entry asks of the back end
	typedef enum logic {
		KIND_KEY  = 1'b0,
		KIND_DATA = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [1:0] sel;
		logic       last;
		logic       trunc;
	} qent_t;

endpackage

`default_nettype wire

FILE: rtl/wsfu_front.sv
// header parser and payload classifier of the websocket frame unmasker
`default_nettype none

module wsfu_front #(
	parameter int LENGTH_BITS = wsfu_pkg::LENGTH_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [7:0]        in_data,
	output logic                   in_ready,
	input  wire logic [31:0]       limit,
	output logic                   push,
	output wsfu_pkg::qent_t        push_ent,
	input  wire logic              push_ready
);

	localparam int CW = (LENGTH_BITS > 33) ? LENGTH_BITS : 33;

	typedef enum logic [4:0] {
		PH_FIRST = 5'b00001,
		PH_LEN   = 5'b00010,
		PH_EXT   = 5'b00100,
		PH_MASK  = 5'b01000,
		PH_DATA  = 5'b10000
	} phase_t;

	phase_t                       phase_q;
	logic [3:0]                   hcnt_q;
	logic [wsfu_pkg::EXT_BITS-1:0] acc_q;
	logic [LENGTH_BITS-1:0]       len_q;
	logic [LENGTH_BITS-1:0]       idx_q;
	logic [LENGTH_BITS-1:0]       rem_q;

	logic                         accept;
	logic [6:0]                   len7;
	logic [wsfu_pkg::EXT_BITS-1:0] acc_next;
	logic [LENGTH_BITS-1:0]       len_sat;
	logic [CW-1:0]                idx_w, lim_w, len_w;
	logic                         emit, hits_lim, is_final, trunc;

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;
	assign len7     = in_data[6:0];
	assign acc_next = {acc_q[wsfu_pkg::EXT_BITS-9:0], in_data};
	assign len_sat  = ((acc_next >> LENGTH_BITS) != '0) ? '1 : acc_next[LENGTH_BITS-1:0];

	assign idx_w    = CW'(idx_q);
	assign lim_w    = CW'(limit);
	assign len_w    = CW'(len_q);
	assign emit     = idx_w < lim_w;
	assign hits_lim = (idx_w + CW'(1)) == lim_w;
	// rem counts bytes still to come, at least one while in payload
	assign is_final = rem_q == LENGTH_BITS'(1);
	assign trunc    = len_w > lim_w;

	always_comb begin
		push_ent.kind  = wsfu_pkg::KIND_KEY;
		push_ent.data  = in_data;
		push_ent.sel   = hcnt_q[1:0];
		push_ent.last  = 1'b0;
		push_ent.trunc = 1'b0;
		push           = 1'b0;
		if (phase_q == PH_MASK) begin
			push = accept;
		end else if (phase_q == PH_DATA) begin
			push_ent.kind  = wsfu_pkg::KIND_DATA;
			push_ent.sel   = idx_q[1:0];
			push_ent.last  = is_final || hits_lim;
			push_ent.trunc = trunc;
			push           = accept && emit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			hcnt_q  <= '0;
			acc_q   <= '0;
			len_q   <= '0;
			idx_q   <= '0;
			rem_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_LEN: begin
					acc_q <= '0;
					len_q <= '0;
					if (len7 == wsfu_pkg::LEN16_CODE) begin
						phase_q <= PH_EXT;
						hcnt_q  <= wsfu_pkg::EXT16_BYTES;
					end else if (len7 == wsfu_pkg::LEN64_CODE) begin
						phase_q <= PH_EXT;
						hcnt_q  <= wsfu_pkg::EXT64_BYTES;
					end else begin
						len_q   <= LENGTH_BITS'(len7);
						phase_q <= PH_MASK;
						hcnt_q  <= '0;
					end
				end
				PH_EXT: begin
					acc_q  <= acc_next;
					hcnt_q <= hcnt_q - 4'd1;
					if (hcnt_q == 4'd1) begin
						len_q   <= len_sat;
						phase_q <= PH_MASK;
						hcnt_q  <= '0;
					end
				end
				PH_MASK: begin
					hcnt_q <= hcnt_q + 4'd1;
					if (hcnt_q == 4'd3) begin
						hcnt_q  <= '0;
						idx_q   <= '0;
						rem_q   <= len_q;
						phase_q <= (len_q == '0) ? PH_FIRST : PH_DATA;
					end
				end
				PH_DATA: begin
					idx_q <= idx_q + LENGTH_BITS'(1);
					rem_q <= rem_q - LENGTH_BITS'(1);
					if (is_final) begin
						phase_q <= PH_FIRST;
						idx_q   <= '0;
					end
				end
				default: begin
					phase_q <= PH_LEN;
					hcnt_q  <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/wsfu_fifo.sv
// short queue between the front and the back of the websocket frame unmasker
`default_nettype none

module wsfu_fifo #(
	parameter int DEPTH = wsfu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire wsfu_pkg::qent_t push_ent,
	output logic                 push_ready,
	input  wire logic            pop,
	output wsfu_pkg::qent_t      pop_ent,
	output logic                 pop_valid
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNW = $clog2(DEPTH + 1);

	wsfu_pkg::qent_t slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNW-1:0]  count_q;
	logic            do_push, do_pop;

	assign push_ready = count_q != CNW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_ent    = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNW'(1);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNW'(DEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_ready)
		else $error("front pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("back popped an empty queue");

endmodule

`default_nettype wire

FILE: rtl/wsfu_back.sv
// mask key store, unmasking and output register of the websocket frame unmasker
`default_nettype none

module wsfu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire wsfu_pkg::qent_t q_ent,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_data,
	output logic                 out_last,
	output logic                 out_trunc
);

	logic [7:0] key_q [4];
	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q, out_trunc_q;
	logic       is_data, load;

	assign is_data = q_ent.kind == wsfu_pkg::KIND_DATA;
	// key beats never wait, payload beats wait for room in the output register
	assign q_pop   = q_valid && (!is_data || !out_valid_q || out_ready);
	assign load    = q_pop && is_data;

	always_ff @(posedge clk) begin
		if (q_pop && !is_data) begin
			key_q[q_ent.sel] <= q_ent.data;
		end
		if (load) begin
			out_data_q  <= q_ent.data ^ key_q[q_ent.sel];
			out_last_q  <= q_ent.last;
			out_trunc_q <= q_ent.trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;
	assign out_trunc = out_trunc_q;

endmodule

`default_nettype wire

FILE: rtl/websocket_frame_unmasker.sv
// top level of the websocket frame unmasker
`default_nettype none

// Receives a client-to-server websocket frame one byte per beat on the s_ side
// and delivers the unmasked payload on the m_ side. The first header byte is
// skipped, the second gives the seven-bit length or announces a 16-bit or
// 64-bit big-endian extended length, four mask key bytes follow, and every
// payload byte leaves XORed with key byte (index mod 4); the mask bit is not
// checked. Only the first payload_limit bytes of a frame come out, the rest
// are consumed and dropped; m_tlast marks the final byte sent for a frame and
// m_tuser is high on every byte of a frame longer than the limit. Header and
// dropped bytes give no output beat. Lengths that do not fit LENGTH_BITS
// saturate. While m_tready stays high the sustained rate is one byte per
// clock on both sides: the header parser updates its state once per accepted
// byte, a four-entry queue parts it from the unmasking stage, and a single
// output register holds the result. A payload byte goes into a queue slot
// when accepted and moves into the output register once the back pops it.
// payload_limit is written through cfg_valid/cfg_data (always ready, reset
// 65535) and should only change while no frame is in flight.
module websocket_frame_unmasker #(
	parameter int LENGTH_BITS = wsfu_pkg::LENGTH_BITS_DEF,
	parameter int QUEUE_DEPTH = wsfu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,   // payload_limit
	// raw frame stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] frame_byte
	// unmasked payload stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,    // [7:0] plain_byte
	output logic             m_tlast,    // last_byte
	output logic             m_tuser     // [0] truncated
);

	logic [31:0]     limit_q;
	logic            push, push_ready, pop, pop_valid;
	wsfu_pkg::qent_t push_ent, pop_ent;

	// payload limit register, compared live at every payload byte
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= wsfu_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// front: header parsing, length and limit bookkeeping
	wsfu_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata),
		.in_ready  (s_tready),
		.limit     (limit_q),
		.push      (push),
		.push_ent  (push_ent),
		.push_ready(push_ready)
	);

	// queue of key and payload beats
	wsfu_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ent  (push_ent),
		.push_ready(push_ready),
		.pop       (pop),
		.pop_ent   (pop_ent),
		.pop_valid (pop_valid)
	);

	// back: key store and unmasking into the output register
	wsfu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_ent    (pop_ent),
		.q_pop    (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_last (m_tlast),
		.out_trunc(m_tuser)
	);

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the websocket frame unmasker
`timescale 1ns / 1ps

module testbench;

	localparam int LEN_BITS = wsfu_pkg::LENGTH_BITS_DEF;
	localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1400;
	// cycles the pipe may still be busy after the last beat (queue plus output stage)
	localparam int DRAIN_CYCLES = 12;

	typedef enum logic [2:0] {
		PS_FIRST,
		PS_LEN,
		PS_EXT,
		PS_KEY,
		PS_DATA
	} parse_state_t;

	typedef enum int {
		LEN_SHORT,
		LEN_EXT16,
		LEN_EXT64
	} len_form_t;

	typedef struct {
		logic [7:0] plain;
		logic       last;
		logic       trunc;
	} plain_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;    // [7:0] plain_byte
	logic        m_tlast;    // last_byte
	logic        m_tuser;    // [0] truncated

	websocket_frame_unmasker uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// raw frame bytes waiting to be sent, unmasked bytes waiting to arrive
	logic [7:0]  wire_bytes[$];
	plain_beat_t pending_plain[$];
	int unsigned queued_bytes = 0;
	int unsigned sent_bytes = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;

	// shadow of the parser
	logic [31:0]  byte_limit = wsfu_pkg::LIMIT_RESET;
	parse_state_t parse_state = PS_FIRST;
	logic [3:0]   hdr_left = '0;
	logic [63:0]  frame_len = '0;
	logic [7:0]   key_bytes[4] = '{default: 8'h00};
	logic [63:0]  pay_pos = '0;

	// advance the shadow parser by one frame byte, return 1 when a beat is due
	function automatic bit unmask_byte(input logic [7:0] b, output plain_beat_t beat);
		logic [63:0] lim;
		logic        at_end;
		bit          due;

		due = 1'b0;
		beat = '{plain: 8'h00, last: 1'b0, trunc: 1'b0};
		lim = {32'd0, byte_limit};
		case (parse_state)
			PS_LEN: begin
				frame_len = '0;
				if (b[6:0] == wsfu_pkg::LEN16_CODE) begin
					parse_state = PS_EXT;
					hdr_left = wsfu_pkg::EXT16_BYTES;
				end else if (b[6:0] == wsfu_pkg::LEN64_CODE) begin
					parse_state = PS_EXT;
					hdr_left = wsfu_pkg::EXT64_BYTES;
				end else begin
					frame_len = {57'd0, b[6:0]};
					parse_state = PS_KEY;
					hdr_left = '0;
				end
			end
			PS_EXT: begin
				frame_len = {frame_len[55:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 4'd0) begin
					if (frame_len > LEN_MAX)
						frame_len = LEN_MAX;
					parse_state = PS_KEY;
				end
			end
			PS_KEY: begin
				key_bytes[hdr_left[1:0]] = b;
				hdr_left = hdr_left + 4'd1;
				if (hdr_left >= 4'd4) begin
					hdr_left = '0;
					pay_pos = '0;
					parse_state = (frame_len == 64'd0) ? PS_FIRST : PS_DATA;
				end
			end
			PS_DATA: begin
				at_end = (pay_pos + 64'd1 >= frame_len);
				if (pay_pos < lim) begin
					beat.plain = b ^ key_bytes[pay_pos[1:0]];
					beat.last = at_end || (pay_pos + 64'd1 == lim);
					beat.trunc = (frame_len > lim);
					due = 1'b1;
				end
				pay_pos = (pay_pos + 64'd1) & LEN_MAX;
				if (at_end) begin
					parse_state = PS_FIRST;
					pay_pos = '0;
				end
			end
			default: begin
				parse_state = PS_LEN;
				hdr_left = '0;
			end
		endcase
		return due;
	endfunction

	// sender: one byte per beat, random gaps between bytes with gap-free stretches
	int unsigned tx_gap = 0;
	bit          tx_steady = 1'b0;
	plain_beat_t tx_beat;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				sent_bytes++;
				if (unmask_byte(s_tdata, tx_beat))
					pending_plain.push_back(tx_beat);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (wire_bytes.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= wire_bytes.pop_front();
					if ($urandom_range(0, 31) == 0)
						tx_steady = !tx_steady;
					tx_gap = tx_steady ? 0 : $urandom_range(0, 3);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each beat against the oldest expected byte, then stall at random
	int unsigned rx_hold = 0;
	bit          rx_steady = 1'b0;
	plain_beat_t rx_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_plain.size() == 0) begin
					$error("unexpected beat: plain_byte %02h last_byte %0b truncated %0b",
						m_tdata, m_tlast, m_tuser);
					errors++;
				end else begin
					rx_want = pending_plain.pop_front();
					if (m_tdata !== rx_want.plain) begin
						$error("plain_byte: expected %02h, got %02h", rx_want.plain, m_tdata);
						errors++;
					end
					if (m_tlast !== rx_want.last) begin
						$error("last_byte: expected %0b, got %0b", rx_want.last, m_tlast);
						errors++;
					end
					if (m_tuser !== rx_want.trunc) begin
						$error("truncated: expected %0b, got %0b", rx_want.trunc, m_tuser);
						errors++;
					end
				end
				if ($urandom_range(0, 31) == 0)
					rx_steady = !rx_steady;
				rx_hold = rx_steady ? 0 : $urandom_range(0, 3);
			end else if (rx_hold != 0) begin
				rx_hold--;
			end
			m_tready <= (rx_hold == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		wire_bytes.push_back(b);
		queued_bytes++;
	endtask

	// one client frame: header, length, key, then 'sent' random payload bytes
	task automatic queue_frame(input logic [7:0] head, input len_form_t form,
			input logic [63:0] len, input int unsigned sent);
		logic [6:0]  code;
		int unsigned ext_n;
		int unsigned n;

		case (form)
			LEN_EXT16: begin
				code = wsfu_pkg::LEN16_CODE;
				ext_n = int'(wsfu_pkg::EXT16_BYTES);
			end
			LEN_EXT64: begin
				code = wsfu_pkg::LEN64_CODE;
				ext_n = int'(wsfu_pkg::EXT64_BYTES);
			end
			default: begin
				code = len[6:0];
				ext_n = 0;
			end
		endcase
		push_byte(head);
		push_byte({1'($urandom_range(0, 1)), code});
		for (n = ext_n; n > 0; n--)
			push_byte(len[8 * n - 1 -: 8]);
		for (n = 0; n < 4; n++)
			push_byte(8'($urandom));
		for (n = 0; n < sent; n++)
			push_byte(8'($urandom));
	endtask

	task automatic queue_random_frame();
		logic [63:0] len;
		int unsigned pick;

		pick = $urandom_range(0, 19);
		if (pick < 14) begin
			len = 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 125)
				: $urandom_range(0, 20));
			queue_frame(8'($urandom), LEN_SHORT, len, 32'(len));
		end else if (pick < 17) begin
			len = 64'($urandom_range(0, 300));
			queue_frame(8'($urandom), LEN_EXT16, len, 32'(len));
		end else begin
			len = 64'($urandom_range(0, 40));
			queue_frame(8'($urandom), LEN_EXT64, len, 32'(len));
		end
	endtask

	// wait for every byte to be taken and every beat to come back, then for the pipe
	task automatic settle();
		while (sent_bytes != queued_bytes || pending_plain.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		byte_limit = value;
		cfg_valid <= 1'b0;
	endtask

	int unsigned phase_no;
	int unsigned frame_cnt;
	int unsigned f;
	logic [31:0] next_limit;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty payload, one byte behind a full header byte, 16-bit length form
		queue_frame(8'h00, LEN_SHORT, 64'd0, 0);
		queue_frame(8'hFF, LEN_SHORT, 64'd1, 1);
		queue_frame(8'h81, LEN_EXT16, 64'd2, 2);
		settle();

		// random phases, each under its own limit; the first ones hit the extremes
		phase_no = 0;
		while (queued_bytes < ITEM_TARGET) begin
			case (phase_no)
				0: next_limit = 32'd0;
				1: next_limit = 32'd1;
				2: next_limit = 32'hFFFF_FFFF;
				3: next_limit = 32'd3;
				default: begin
					case ($urandom_range(0, 5))
						0: next_limit = 32'd0;
						1: next_limit = $urandom_range(1, 8);
						2: next_limit = 32'hFFFF_FFFF;
						3: next_limit = $urandom;
						4: next_limit = $urandom_range(1, 130);
						default: next_limit = wsfu_pkg::LIMIT_RESET;
					endcase
				end
			endcase
			write_limit(next_limit);
			frame_cnt = $urandom_range(3, 10);
			for (f = 0; f < frame_cnt; f++)
				queue_random_frame();
			settle();
			phase_no++;
		end

		// a frame with an all-ones 64-bit length never ends, so it closes the run
		write_limit($urandom_range(1, 30));
		queue_frame(8'($urandom), LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 40);
		settle();

		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/wsfu_pkg.sv
rtl/wsfu_front.sv
rtl/wsfu_fifo.sv
rtl/wsfu_back.sv
rtl/websocket_frame_unmasker.sv
sim/testbench.sv
